@@ rtl/lrmp_pkg.sv @@
// ---------------------------------------------------------------------------
// lrmp_pkg: shared types and constants of the composition counter
// Modulus, word widths, cell operation codes, cell control bundle and the
// modular add used by both the cells and the controller.
// ---------------------------------------------------------------------------
`default_nettype none

package lrmp_pkg;

  localparam int unsigned WORD_W     = 30;
  localparam int unsigned LEN_W      = 60;
  localparam int unsigned LOW_W      = 64;
  localparam int unsigned HIGH_W     = 36;
  localparam int unsigned SIZE_LIMIT = LOW_W + HIGH_W;
  localparam int unsigned BIT_W      = 5;
  localparam int unsigned CFG_IDX_W  = 8;

  localparam logic [WORD_W-1:0]    MOD_P    = WORD_W'(1000000007);
  localparam logic [WORD_W-1:0]    WORD_ONE = WORD_W'(1);
  localparam logic [BIT_W-1:0]     BIT_TOP  = BIT_W'(WORD_W - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_SET_A_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SET_A_HIGH = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SET_B_LOW  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SET_B_HIGH = CFG_IDX_W'(3);

  typedef enum logic [3:0] {
    OP_HOLD,
    OP_INIT,
    OP_ROT,
    OP_PUSH,
    OP_LOAD,
    OP_SHIFT,
    OP_PCLR,
    OP_MUL,
    OP_ADD,
    OP_STORE,
    OP_DSHIFT
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic              sq;
    logic              dot;
    logic [BIT_W-1:0]  bit_idx;
    logic [WORD_W-1:0] scalar;
    logic [WORD_W-1:0] tval;
  } cell_ctrl_t;

  function automatic logic [WORD_W-1:0] mod_add(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
    logic [WORD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, MOD_P}) begin
      s = s - {1'b0, MOD_P};
    end
    return s[WORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/lrmp_if.sv @@
// ---------------------------------------------------------------------------
// lrmp_if: channel interfaces of the composition counter
// Length request, count response and register write channels.
// ---------------------------------------------------------------------------
`default_nettype none

interface lrmp_len_if;
  logic        valid;
  logic        ready;
  logic [59:0] total_length;
  modport source (output valid, output total_length, input ready);
  modport sink   (input valid, input total_length, output ready);
endinterface

interface lrmp_ways_if;
  logic        valid;
  logic        ready;
  logic [29:0] way_count;
  modport source (output valid, output way_count, input ready);
  modport sink   (input valid, input way_count, output ready);
endinterface

interface lrmp_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/lrmp_cell.sv @@
// ---------------------------------------------------------------------------
// lrmp_cell: one coefficient slot of the polynomial chain
// Holds one coefficient of the result, base, accumulator and term window,
// and runs a bit-serial modular multiply.
// ---------------------------------------------------------------------------
`default_nettype none

module lrmp_cell
  import lrmp_pkg::*;
#(
  parameter int unsigned INDEX = 0
) (
  input  wire logic              clk_i,
  input  wire cell_ctrl_t        ctrl_i,
  input  wire logic              allow_i,
  input  wire logic [WORD_W-1:0] acc_prev_i,
  input  wire logic [WORD_W-1:0] xs_prev_i,
  input  wire logic [WORD_W-1:0] w_prev_i,
  input  wire logic [WORD_W-1:0] w_next_i,
  input  wire logic [WORD_W-1:0] tv_next_i,
  input  wire logic [WORD_W-1:0] prod_next_i,
  output logic [WORD_W-1:0]      acc_o,
  output logic [WORD_W-1:0]      xs_o,
  output logic [WORD_W-1:0]      w_o,
  output logic [WORD_W-1:0]      tv_o,
  output logic [WORD_W-1:0]      prod_o
);

  logic [WORD_W-1:0] r_q, b_q, acc_q, xs_q, w_q, tv_q, prod_q;
  logic [WORD_W-1:0] mul_s, mul_y, dbl, step_d;

  always_comb begin
    mul_s  = ctrl_i.dot ? r_q : ctrl_i.scalar;
    mul_y  = ctrl_i.dot ? tv_q : b_q;
    dbl    = mod_add(prod_q, prod_q);
    step_d = mul_s[ctrl_i.bit_idx] ? mod_add(dbl, mul_y) : dbl;
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OP_INIT: begin
        r_q <= (INDEX == 0) ? WORD_ONE : '0;
        b_q <= (INDEX == 1) ? WORD_ONE : '0;
        w_q <= (INDEX == 0) ? WORD_ONE : '0;
      end
      OP_ROT:  w_q <= w_next_i;
      OP_PUSH: begin
        w_q  <= w_prev_i;
        tv_q <= tv_next_i;
      end
      OP_LOAD: begin
        xs_q  <= ctrl_i.sq ? b_q : r_q;
        acc_q <= '0;
      end
      // multiply by x: shift up and fold the top coefficient back in
      OP_SHIFT: begin
        acc_q  <= mod_add(acc_prev_i, allow_i ? ctrl_i.tval : '0);
        prod_q <= '0;
      end
      OP_PCLR: prod_q <= '0;
      OP_MUL:  prod_q <= step_d;
      OP_ADD: begin
        acc_q <= mod_add(acc_q, prod_q);
        xs_q  <= xs_prev_i;
      end
      OP_STORE: begin
        if (ctrl_i.sq) begin
          b_q <= acc_q;
        end else begin
          r_q <= acc_q;
        end
      end
      OP_DSHIFT: prod_q <= prod_next_i;
      default: ;
    endcase
  end

  assign acc_o  = acc_q;
  assign xs_o   = xs_q;
  assign w_o    = w_q;
  assign tv_o   = tv_q;
  assign prod_o = prod_q;

endmodule

`default_nettype wire

@@ rtl/linear_recurrence_matrix_power_mod.sv @@
// ---------------------------------------------------------------------------
// linear_recurrence_matrix_power_mod: composition counter modulo 1000000007
// Counts ordered compositions of n into parts allowed by both size sets.
// ---------------------------------------------------------------------------
// One request at a time. A length of zero answers with a count of one and
// does not use the cells. Otherwise the block builds the first ORDER terms,
// then forms x^(n-1) modulo the characteristic polynomial by square and
// multiply, with one polynomial product and its decision step per bit of
// n-1 below the top plus one per set bit. A final dot product gives the
// count. The chain of ORDER cells, each with a bit-serial modular multiplier
// of 30 steps, runs every one of these products.
`default_nettype none

module linear_recurrence_matrix_power_mod
  import lrmp_pkg::*;
#(
  parameter int unsigned ORDER = 100
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lrmp_len_if.sink   req_i,
  lrmp_ways_if.source rsp_o,
  lrmp_cfg_if.sink   cfg_i
);

  localparam int unsigned CW = $clog2(ORDER);
  localparam logic [CW-1:0] LAST = CW'(ORDER - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_BUILD_ROT, ST_BUILD_PUSH, ST_EXP, ST_LOAD, ST_SHIFT, ST_MUL,
    ST_ADD, ST_STORE, ST_DCLR, ST_DMUL, ST_DSUM, ST_OUT
  } state_e;

  state_e             state_q;
  logic [LOW_W-1:0]   a_low_q, b_low_q;
  logic [HIGH_W-1:0]  a_high_q, b_high_q;
  logic [LEN_W-1:0]   e_q;
  logic [CW-1:0]      c_q, i_q;
  logic [BIT_W-1:0]   bit_q;
  logic [WORD_W-1:0]  sum_q, res_q;
  logic               sq_q, did_mul_q;

  logic [SIZE_LIMIT-1:0] size_mask;
  logic [ORDER-1:0]      allowed;
  cell_ctrl_t            ctrl;

  logic [WORD_W-1:0] acc_w [ORDER];
  logic [WORD_W-1:0] xs_w  [ORDER];
  logic [WORD_W-1:0] w_w   [ORDER];
  logic [WORD_W-1:0] tv_w  [ORDER];
  logic [WORD_W-1:0] prod_w[ORDER];

  assign size_mask = {a_high_q, a_low_q} & {b_high_q, b_low_q};

  // bit p-1 marks part size p
  for (genvar p = 0; p < ORDER; p++) begin : g_allow
    if (p < SIZE_LIMIT) begin : g_in
      assign allowed[p] = size_mask[p];
    end else begin : g_out
      assign allowed[p] = 1'b0;
    end
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_low_q  <= '0;
      a_high_q <= '0;
      b_low_q  <= '0;
      b_high_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_SET_A_LOW:  a_low_q  <= cfg_i.data;
        CFG_SET_A_HIGH: a_high_q <= cfg_i.data[HIGH_W-1:0];
        CFG_SET_B_LOW:  b_low_q  <= cfg_i.data;
        CFG_SET_B_HIGH: b_high_q <= cfg_i.data[HIGH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ctrl.sq      = sq_q;
    ctrl.dot     = (state_q == ST_DMUL);
    ctrl.bit_idx = bit_q;
    ctrl.scalar  = xs_w[ORDER-1];
    ctrl.tval    = acc_w[ORDER-1];
    case (state_q)
      ST_IDLE:       ctrl.op = (req_i.valid && req_i.total_length != '0) ? OP_INIT
                                                                        : OP_HOLD;
      ST_BUILD_ROT:  ctrl.op = OP_ROT;
      ST_BUILD_PUSH: ctrl.op = OP_PUSH;
      ST_LOAD:       ctrl.op = OP_LOAD;
      ST_SHIFT:      ctrl.op = OP_SHIFT;
      ST_MUL:        ctrl.op = OP_MUL;
      ST_ADD:        ctrl.op = OP_ADD;
      ST_STORE:      ctrl.op = OP_STORE;
      ST_DCLR:       ctrl.op = OP_PCLR;
      ST_DMUL:       ctrl.op = OP_MUL;
      ST_DSUM:       ctrl.op = OP_DSHIFT;
      default:       ctrl.op = OP_HOLD;
    endcase
  end

  assign req_i.ready     = (state_q == ST_IDLE);
  assign rsp_o.valid     = (state_q == ST_OUT);
  assign rsp_o.way_count = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      e_q       <= '0;
      c_q       <= '0;
      i_q       <= '0;
      bit_q     <= '0;
      sum_q     <= '0;
      res_q     <= '0;
      sq_q      <= 1'b0;
      did_mul_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (req_i.valid) begin
            if (req_i.total_length == '0) begin
              res_q   <= WORD_ONE;
              state_q <= ST_OUT;
            end else begin
              e_q       <= req_i.total_length - LEN_W'(1);
              sum_q     <= '0;
              c_q       <= '0;
              i_q       <= '0;
              did_mul_q <= 1'b0;
              state_q   <= ST_BUILD_ROT;
            end
          end
        end
        // window head holds f(i-p) for p = c+1
        ST_BUILD_ROT: begin
          if (allowed[c_q]) begin
            sum_q <= mod_add(sum_q, w_w[0]);
          end
          if (c_q == LAST) begin
            c_q     <= '0;
            state_q <= ST_BUILD_PUSH;
          end else begin
            c_q <= c_q + CW'(1);
          end
        end
        ST_BUILD_PUSH: begin
          sum_q <= '0;
          if (i_q == LAST) begin
            state_q <= ST_EXP;
          end else begin
            i_q     <= i_q + CW'(1);
            state_q <= ST_BUILD_ROT;
          end
        end
        ST_EXP: begin
          if (e_q == '0) begin
            state_q <= ST_DCLR;
          end else if (e_q[0] && !did_mul_q) begin
            sq_q    <= 1'b0;
            state_q <= ST_LOAD;
          end else if (e_q > LEN_W'(1)) begin
            sq_q    <= 1'b1;
            state_q <= ST_LOAD;
          end else begin
            e_q       <= e_q >> 1;
            did_mul_q <= 1'b0;
          end
        end
        ST_LOAD: begin
          i_q     <= '0;
          state_q <= ST_SHIFT;
        end
        ST_SHIFT: begin
          bit_q   <= BIT_TOP;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          if (bit_q == '0) begin
            state_q <= ST_ADD;
          end else begin
            bit_q <= bit_q - BIT_W'(1);
          end
        end
        ST_ADD: begin
          if (i_q == LAST) begin
            state_q <= ST_STORE;
          end else begin
            i_q     <= i_q + CW'(1);
            state_q <= ST_SHIFT;
          end
        end
        ST_STORE: begin
          if (sq_q) begin
            e_q       <= e_q >> 1;
            did_mul_q <= 1'b0;
          end else begin
            did_mul_q <= 1'b1;
          end
          state_q <= ST_EXP;
        end
        ST_DCLR: begin
          res_q   <= '0;
          bit_q   <= BIT_TOP;
          state_q <= ST_DMUL;
        end
        ST_DMUL: begin
          if (bit_q == '0) begin
            c_q     <= '0;
            state_q <= ST_DSUM;
          end else begin
            bit_q <= bit_q - BIT_W'(1);
          end
        end
        // drain products down the chain into the result
        ST_DSUM: begin
          res_q <= mod_add(res_q, prod_w[0]);
          if (c_q == LAST) begin
            state_q <= ST_OUT;
          end else begin
            c_q <= c_q + CW'(1);
          end
        end
        ST_OUT: begin
          if (rsp_o.ready) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  for (genvar k = 0; k < ORDER; k++) begin : g_cell
    logic [WORD_W-1:0] acc_prev, xs_prev, w_prev, w_next, tv_next, prod_next;

    if (k == 0) begin : g_first
      assign acc_prev = '0;
      assign xs_prev  = '0;
      assign w_prev   = sum_q;
    end else begin : g_mid
      assign acc_prev = acc_w[k-1];
      assign xs_prev  = xs_w[k-1];
      assign w_prev   = w_w[k-1];
    end

    if (k == ORDER - 1) begin : g_last
      assign w_next    = w_w[0];
      assign tv_next   = sum_q;
      assign prod_next = '0;
    end else begin : g_body
      assign w_next    = w_w[k+1];
      assign tv_next   = tv_w[k+1];
      assign prod_next = prod_w[k+1];
    end

    lrmp_cell #(
      .INDEX(k)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .allow_i    (allowed[ORDER-1-k]),
      .acc_prev_i (acc_prev),
      .xs_prev_i  (xs_prev),
      .w_prev_i   (w_prev),
      .w_next_i   (w_next),
      .tv_next_i  (tv_next),
      .prod_next_i(prod_next),
      .acc_o      (acc_w[k]),
      .xs_o       (xs_w[k]),
      .w_o        (w_w[k]),
      .tv_o       (tv_w[k]),
      .prod_o     (prod_w[k])
    );
  end

endmodule

`default_nettype wire
